// ----- hdl/hcl_pkg.sv -----
// Shared types and constants for the RGB to hue / chroma / lightness converter.
// Used by hcl_sort, hcl_divider and the top level rgb_to_hue_chroma_lightness.
`default_nettype none

package hcl_pkg;

  localparam int CHAN_W  = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 8;
  localparam int LIGHT_W = 9;

  // Which component holds the maximum; grey means all components are equal.
  typedef enum logic [1:0] {
    SEC_GREY,
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hcl_sector_t;

  // Per-pixel information that rides alongside the divider.
  typedef struct packed {
    hcl_sector_t        sector;
    logic               neg;
    logic [SAT_W-1:0]   sat;
    logic [LIGHT_W-1:0] light;
  } hcl_side_t;

endpackage

`default_nettype wire

// ----- hdl/rgb_to_hue_chroma_lightness.sv -----
// Pipeline: one sort stage, one divider load stage, one divider stage per quotient
// bit, and the output register. Throughput: one pixel per cycle while the output
// is not stalled by out_tready.
// The whole pipeline advances together whenever the output register is empty or taken.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on hcl_pkg, hcl_sort and hcl_divider.
`default_nettype none

module rgb_to_hue_chroma_lightness #(
  parameter int HUE_FRACTION_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // hue[14:0], saturation[22:15], lightness_doubled[31:23]
);

  localparam int SCALE = 1 << HUE_FRACTION_BITS;
  localparam int QW    = HUE_FRACTION_BITS + 6;
  localparam int HW    = $clog2(360 * SCALE);

  localparam logic [HW-1:0] HUE_120 = HW'(120 * SCALE);
  localparam logic [HW-1:0] HUE_240 = HW'(240 * SCALE);
  localparam logic [HW-1:0] HUE_360 = HW'(360 * SCALE);

  logic                                en;
  logic                                sort_valid;
  logic [hcl_pkg::CHAN_W-1:0]          sort_mag;
  logic [hcl_pkg::CHAN_W-1:0]          sort_chroma;
  hcl_pkg::hcl_side_t                  sort_side;
  logic                                div_valid;
  logic [QW-1:0]                       div_quot;
  logic                                div_rem_nz;
  hcl_pkg::hcl_side_t                  div_side;

  logic [HW-1:0]                       offs;
  logic [HW-1:0]                       hue_nxt;
  logic                                out_valid_r;
  logic [HW-1:0]                       hue_r;
  logic [hcl_pkg::SAT_W-1:0]           sat_r;
  logic [hcl_pkg::LIGHT_W-1:0]         light_r;
  logic [HW+hcl_pkg::HUE_W-1:0]        hue_ext;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  hcl_sort u_sort (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .red        (in_tdata[7:0]),
    .green      (in_tdata[15:8]),
    .blue       (in_tdata[23:16]),
    .out_valid  (sort_valid),
    .out_mag    (sort_mag),
    .out_chroma (sort_chroma),
    .out_side   (sort_side)
  );

  hcl_divider #(
    .FRAC_BITS (HUE_FRACTION_BITS)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (sort_valid),
    .in_mag     (sort_mag),
    .in_div     (sort_chroma),
    .in_side    (sort_side),
    .out_valid  (div_valid),
    .out_quot   (div_quot),
    .out_rem_nz (div_rem_nz),
    .out_side   (div_side)
  );

  // A negative difference needs the floor, so the quotient is rounded away from zero.
  // In the red sector a negative hue wraps around by a full turn.
  always_comb begin
    unique case (div_side.sector)
      hcl_pkg::SEC_RED:   offs = div_side.neg ? HUE_360 : '0;
      hcl_pkg::SEC_GREEN: offs = HUE_120;
      hcl_pkg::SEC_BLUE:  offs = HUE_240;
      default:            offs = '0;
    endcase

    if (div_side.sector == hcl_pkg::SEC_GREY) begin
      hue_nxt = '0;
    end else if (div_side.neg) begin
      hue_nxt = offs - HW'(div_quot) - HW'(div_rem_nz);
    end else begin
      hue_nxt = offs + HW'(div_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= div_side.sat;
      light_r <= div_side.light;
    end
  end

  assign hue_ext    = {{hcl_pkg::HUE_W{1'b0}}, hue_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {light_r, sat_r, hue_ext[hcl_pkg::HUE_W-1:0]};

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> hue_r < HUE_360)
    else $error("hue beyond a full turn");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r == '0 |-> hue_r == '0)
    else $error("grey pixel with nonzero hue");

  a_light_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> light_r >= {1'b0, sat_r} && light_r[0] == sat_r[0])
    else $error("lightness and chroma inconsistent");

endmodule

`default_nettype wire

// ----- hdl/hcl_sort.sv -----
// First pipeline stage: finds max, min, hue sector and the signed sector difference.
// Depends on hcl_pkg for the sector code and sideband struct.
`default_nettype none

module hcl_sort (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [hcl_pkg::CHAN_W-1:0]   red,
  input  wire logic [hcl_pkg::CHAN_W-1:0]   green,
  input  wire logic [hcl_pkg::CHAN_W-1:0]   blue,
  output logic                              out_valid,
  output logic [hcl_pkg::CHAN_W-1:0]        out_mag,
  output logic [hcl_pkg::CHAN_W-1:0]        out_chroma,
  output hcl_pkg::hcl_side_t                out_side
);

  logic                        valid_r;
  logic [hcl_pkg::CHAN_W-1:0]  mag_r;
  logic [hcl_pkg::CHAN_W-1:0]  chroma_r;
  hcl_pkg::hcl_side_t          side_r;

  logic [hcl_pkg::CHAN_W-1:0]  mx;
  logic [hcl_pkg::CHAN_W-1:0]  mn;
  logic [hcl_pkg::CHAN_W-1:0]  diff_a;
  logic [hcl_pkg::CHAN_W-1:0]  diff_b;
  logic [hcl_pkg::CHAN_W:0]    diff;
  logic [hcl_pkg::CHAN_W-1:0]  chroma_nxt;
  logic [hcl_pkg::CHAN_W-1:0]  mag_nxt;
  hcl_pkg::hcl_side_t          side_nxt;

  always_comb begin
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    // Red wins ties over green, green over blue.
    if (red >= green && red >= blue) begin
      mx     = red;
      diff_a = green;
      diff_b = blue;
      side_nxt.sector = hcl_pkg::SEC_RED;
    end else if (green >= blue) begin
      mx     = green;
      diff_a = blue;
      diff_b = red;
      side_nxt.sector = hcl_pkg::SEC_GREEN;
    end else begin
      mx     = blue;
      diff_a = red;
      diff_b = green;
      side_nxt.sector = hcl_pkg::SEC_BLUE;
    end

    chroma_nxt = mx - mn;
    if (chroma_nxt == '0) side_nxt.sector = hcl_pkg::SEC_GREY;

    diff           = {1'b0, diff_a} - {1'b0, diff_b};
    side_nxt.neg   = diff[hcl_pkg::CHAN_W];
    mag_nxt        = side_nxt.neg ? (diff_b - diff_a) : diff[hcl_pkg::CHAN_W-1:0];
    side_nxt.sat   = chroma_nxt;
    side_nxt.light = {1'b0, mx} + {1'b0, mn};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r    <= mag_nxt;
      chroma_r <= chroma_nxt;
      side_r   <= side_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_mag    = mag_r;
  assign out_chroma = chroma_r;
  assign out_side   = side_r;

endmodule

`default_nettype wire

// ----- hdl/hcl_divider.sv -----
// Pipelined restoring divider: floor(60 * 2^FRAC_BITS * mag / chroma), one quotient
// bit per stage, with a flag for a nonzero remainder. Depends on hcl_pkg.
`default_nettype none

module hcl_divider #(
  parameter int FRAC_BITS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [hcl_pkg::CHAN_W-1:0]    in_mag,
  input  wire logic [hcl_pkg::CHAN_W-1:0]    in_div,
  input  wire hcl_pkg::hcl_side_t            in_side,
  output logic                               out_valid,
  output logic [FRAC_BITS+5:0]               out_quot,
  output logic                               out_rem_nz,
  output hcl_pkg::hcl_side_t                 out_side
);

  // The quotient never exceeds 60 * 2^FRAC_BITS, which fits in FRAC_BITS + 6 bits.
  localparam int QW = FRAC_BITS + 6;
  localparam int NW = QW + hcl_pkg::CHAN_W;
  localparam int MW = hcl_pkg::CHAN_W + 6;

  logic                        valid_r [0:QW];
  logic [hcl_pkg::CHAN_W-1:0]  rem_r   [0:QW];
  logic [QW-1:0]               low_r   [0:QW-1];
  logic [QW-1:0]               quot_r  [0:QW];
  logic [hcl_pkg::CHAN_W-1:0]  div_r   [0:QW];
  hcl_pkg::hcl_side_t          side_r  [0:QW];

  logic [MW-1:0]               mag60;
  logic [NW-1:0]               num;

  // 60 * mag as 64 * mag - 4 * mag, then scaled to hue fraction units.
  assign mag60 = (MW'(in_mag) << 6) - (MW'(in_mag) << 2);
  assign num   = NW'(mag60) << FRAC_BITS;

  // Load stage: the upper bits of the numerator are already below the divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num[NW-1:QW];
      low_r[0]  <= num[QW-1:0];
      quot_r[0] <= '0;
      div_r[0]  <= in_div;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [hcl_pkg::CHAN_W:0]    trial;
    logic                        take;
    logic [hcl_pkg::CHAN_W:0]    diff;
    logic [hcl_pkg::CHAN_W-1:0]  rem_nxt;

    assign trial   = {rem_r[k], low_r[k][QW-1]};
    assign diff    = trial - {1'b0, div_r[k]};
    assign take    = trial >= {1'b0, div_r[k]};
    assign rem_nxt = take ? diff[hcl_pkg::CHAN_W-1:0] : trial[hcl_pkg::CHAN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        quot_r[k+1] <= {quot_r[k][QW-2:0], take};
        div_r[k+1]  <= div_r[k];
        side_r[k+1] <= side_r[k];
      end
    end

    if (k < QW - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en) begin
          low_r[k+1] <= low_r[k] << 1;
        end
      end
    end
  end

  assign out_valid  = valid_r[QW];
  assign out_quot   = quot_r[QW];
  assign out_rem_nz = |rem_r[QW];
  assign out_side   = side_r[QW];

endmodule

`default_nettype wire
